/* hw/rtl/cc20_pkg.sv */
// Shared types and constants of the ChaCha20 stream cipher.
package cc20_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd5;

    typedef logic [31:0] t_word;
    typedef logic [15:0][31:0] t_block;

    localparam t_word SIGMA0 = 32'h6170_7865;
    localparam t_word SIGMA1 = 32'h3320_646e;
    localparam t_word SIGMA2 = 32'h7962_2d32;
    localparam t_word SIGMA3 = 32'h6b20_6574;

endpackage

/* hw/rtl/cc20_in_if.sv */
// Input channel of the cipher: one data byte per request.
interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hw/rtl/cc20_out_if.sv */
// Output channel of the cipher: one transformed byte per request.
interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_out;
    logic       counter_wrapped;

    modport source (output valid, output out_byte, output last_out,
                    output counter_wrapped, input ready);
    modport sink (input valid, input out_byte, input last_out,
                  input counter_wrapped, output ready);
endinterface

/* hw/rtl/cc20_core.sv */
// Keystream block generator built around one shared quarter-round step unit.
module cc20_core import cc20_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_block     i_init,
    input  logic [5:0] i_byte_sel,
    output logic       o_done,
    output logic [7:0] o_ks_byte
);

    localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_FF} t_cstate;

    t_cstate          r_state;
    logic [1:0]       r_step;
    logic [1:0]       r_quarter;
    logic             r_diag;
    logic [RND_W-1:0] r_round;
    t_block           r_w;
    t_word            r_ks [16];

    t_word      u_p, u_q, u_r, u_sum, u_mix, u_rot;
    t_block     n_w;
    t_block     n_step;
    logic       last_step;
    logic [1:0] row_k [4];

    always_comb begin
        if (r_step[0] == 1'b0) begin
            u_p = r_w[0];
            u_q = r_w[4];
            u_r = r_w[12];
        end else begin
            u_p = r_w[8];
            u_q = r_w[12];
            u_r = r_w[4];
        end
        u_sum = u_p + u_q;
        u_mix = u_r ^ u_sum;
        case (r_step)
            2'd0:    u_rot = {u_mix[15:0], u_mix[31:16]};
            2'd1:    u_rot = {u_mix[19:0], u_mix[31:20]};
            2'd2:    u_rot = {u_mix[23:0], u_mix[31:24]};
            2'd3:    u_rot = {u_mix[24:0], u_mix[31:25]};
            default: u_rot = u_mix;
        endcase
    end

    always_comb begin
        n_step = r_w;
        if (r_step[0] == 1'b0) begin
            n_step[0]  = u_sum;
            n_step[12] = u_rot;
        end else begin
            n_step[8] = u_sum;
            n_step[4] = u_rot;
        end
    end

    // After each quarter round the rows turn left by one, so that the next column or
    // diagonal comes to column zero; the last quarter of a round also aligns or
    // restores the diagonals.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            if (r_step != 2'd3) begin
                row_k[r] = 2'd0;
            end else if (r_quarter != 2'd3) begin
                row_k[r] = 2'd1;
            end else if (r_diag) begin
                row_k[r] = 2'(1 - r);
            end else begin
                row_k[r] = 2'(1 + r);
            end
        end
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                n_w[4*r + j] = n_step[{2'(r), 2'(j) + row_k[r]}];
            end
        end
    end

    assign last_step = (r_step == 2'd3) && (r_quarter == 2'd3) && r_diag
                       && (r_round == RND_W'(DOUBLE_ROUNDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= C_IDLE;
            r_step    <= '0;
            r_quarter <= '0;
            r_diag    <= 1'b0;
            r_round   <= '0;
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_w       <= i_init;
                        r_step    <= '0;
                        r_quarter <= '0;
                        r_diag    <= 1'b0;
                        r_round   <= '0;
                        r_state   <= C_RUN;
                    end
                end
                C_RUN: begin
                    r_w    <= n_w;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_quarter <= r_quarter + 2'd1;
                        if (r_quarter == 2'd3) begin
                            r_diag <= ~r_diag;
                            if (r_diag) begin
                                r_round <= r_round + RND_W'(1);
                            end
                        end
                    end
                    if (last_step) begin
                        r_state <= C_FF;
                    end
                end
                C_FF: begin
                    for (int i = 0; i < 16; i++) begin
                        r_ks[i] <= r_w[i] + i_init[i];
                    end
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done    = (r_state == C_FF);
    assign o_ks_byte = r_ks[i_byte_sel[5:2]][{i_byte_sel[1:0], 3'b000} +: 8];

endmodule

/* hw/rtl/chacha20_stream_cipher.sv */
// Top level of the ChaCha20 stream cipher with 64-bit counter and 64-bit nonce.
//
//   channel   direction  contents
//   i_in      in         data_byte, last_byte
//   o_out     out        out_byte, last_out, counter_wrapped
//   i_cfg_*   in         register index and 64-bit value, write only
//
// A byte taken from the current keystream block is accepted and its result is
// registered in that same cycle, so bytes flow at one per cycle while the
// output is taken. The byte that opens a new block waits for the quarter-round
// unit, which does one step per cycle. Reset is synchronous and leaves the
// keystream used up with the counter at zero.
module chacha20_stream_cipher import cc20_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cc20_in_if.sink               i_in,
    cc20_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    typedef enum logic [1:0] {S_IDLE, S_BUILD, S_EMIT} t_state;

    t_state           r_state;
    logic [3:0][63:0] r_key;
    logic [63:0]      r_nonce;
    logic [63:0]      r_start_blk;
    logic [63:0]      r_counter;
    logic [6:0]       r_pos;
    logic             r_wrap;
    logic [7:0]       r_data;
    logic             r_last;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_wrap;

    t_block     init_blk;
    logic       in_acc;
    logic       core_start;
    logic       core_done;
    logic [7:0] ks_byte;
    logic       cfg_hit;

    always_comb begin
        init_blk[0]  = SIGMA0;
        init_blk[1]  = SIGMA1;
        init_blk[2]  = SIGMA2;
        init_blk[3]  = SIGMA3;
        for (int k = 0; k < 4; k++) begin
            init_blk[4 + 2*k] = r_key[k][31:0];
            init_blk[5 + 2*k] = r_key[k][63:32];
        end
        init_blk[12] = r_counter[31:0];
        init_blk[13] = r_counter[63:32];
        init_blk[14] = r_nonce[31:0];
        init_blk[15] = r_nonce[63:32];
    end

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;
    assign core_start = in_acc && r_pos[6];
    assign cfg_hit    = (i_cfg_index == CFG_KEY0) || (i_cfg_index == CFG_KEY1)
                        || (i_cfg_index == CFG_KEY2) || (i_cfg_index == CFG_KEY3)
                        || (i_cfg_index == CFG_NONCE) || (i_cfg_index == CFG_START);

    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (core_start),
        .i_init     (init_blk),
        .i_byte_sel (r_pos[5:0]),
        .o_done     (core_done),
        .o_ks_byte  (ks_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key       <= '0;
            r_nonce     <= '0;
            r_start_blk <= '0;
            r_counter   <= '0;
            r_pos       <= 7'd64;
            r_wrap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_pos[6]) begin
                            r_data  <= i_in.data_byte;
                            r_last  <= i_in.last_byte;
                            r_state <= S_BUILD;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_byte  <= i_in.data_byte ^ ks_byte;
                            r_out_last  <= i_in.last_byte;
                            r_out_wrap  <= r_wrap;
                            r_pos       <= r_pos + 7'd1;
                        end
                    end
                end
                S_BUILD: begin
                    if (core_done) begin
                        r_counter <= r_counter + 64'd1;
                        if (&r_counter) begin
                            r_wrap <= 1'b1;
                        end
                        r_pos   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= r_data ^ ks_byte;
                    r_out_last  <= r_last;
                    r_out_wrap  <= r_wrap;
                    r_pos       <= 7'd1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_we && cfg_hit) begin
                case (i_cfg_index)
                    CFG_KEY0:  r_key[0]    <= i_cfg_wdata;
                    CFG_KEY1:  r_key[1]    <= i_cfg_wdata;
                    CFG_KEY2:  r_key[2]    <= i_cfg_wdata;
                    CFG_KEY3:  r_key[3]    <= i_cfg_wdata;
                    CFG_NONCE: r_nonce     <= i_cfg_wdata;
                    CFG_START: r_start_blk <= i_cfg_wdata;
                    default:   r_nonce     <= r_nonce;
                endcase
                r_counter <= (i_cfg_index == CFG_START) ? i_cfg_wdata : r_start_blk;
                r_pos     <= 7'd64;
                r_wrap    <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.out_byte        = r_out_byte;
    assign o_out.last_out        = r_out_last;
    assign o_out.counter_wrapped = r_out_wrap;

endmodule

/* sim/tb_chacha20_stream_cipher.sv */
// Self-checking testbench of the ChaCha20 stream cipher, with a keystream predictor.
`timescale 1ns / 100ps

module tb_chacha20_stream_cipher;
    import cc20_pkg::*;

    localparam int ROUNDS = 10;
    localparam int BLOCK_CYCLES = 32 * ROUNDS + 3;
    localparam int QUIET_LIMIT = 8 * BLOCK_CYCLES + 500;
    localparam int PHASE_ITEMS = 267;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE1 = 3'd7;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
        logic       wrapped;
    } t_cipher_result;

    class chacha_scoreboard;
        logic [63:0]    regs [6];
        logic [63:0]    block_ctr;
        t_word          ks_words [16];
        t_word          mix [16];
        int unsigned    byte_pos;
        bit             wrapped;
        t_cipher_result want_q [$];
        int unsigned    errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (ks_words[i]) ks_words[i] = '0;
            block_ctr = '0;
            byte_pos = 64;
            wrapped = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
            if (idx > CFG_START) begin
                return;
            end
            regs[idx] = val;
            block_ctr = regs[CFG_START];
            byte_pos = 64;
            wrapped = 1'b0;
        endfunction

        function t_word rotl(t_word v, int s);
            return (v << s) | (v >> (32 - s));
        endfunction

        function void quarter(int a, int b, int c, int d);
            mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
            mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
            mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
            mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
        endfunction

        function void refill();
            t_word init [16];
            init[0] = SIGMA0;
            init[1] = SIGMA1;
            init[2] = SIGMA2;
            init[3] = SIGMA3;
            for (int n = 0; n < 4; n++) begin
                init[4 + 2 * n] = regs[n][31:0];
                init[5 + 2 * n] = regs[n][63:32];
            end
            init[12] = block_ctr[31:0];
            init[13] = block_ctr[63:32];
            init[14] = regs[CFG_NONCE][31:0];
            init[15] = regs[CFG_NONCE][63:32];
            mix = init;
            for (int r = 0; r < ROUNDS; r++) begin
                quarter(0, 4, 8, 12);
                quarter(1, 5, 9, 13);
                quarter(2, 6, 10, 14);
                quarter(3, 7, 11, 15);
                quarter(0, 5, 10, 15);
                quarter(1, 6, 11, 12);
                quarter(2, 7, 8, 13);
                quarter(3, 4, 9, 14);
            end
            foreach (ks_words[i]) ks_words[i] = mix[i] + init[i];
            block_ctr += 64'd1;
            if (block_ctr == '0) begin
                wrapped = 1'b1;
            end
        endfunction

        function void note_request(logic [7:0] d, logic l);
            t_cipher_result res;
            t_word          w;
            if (byte_pos >= 64) begin
                refill();
                byte_pos = 0;
            end
            w = ks_words[byte_pos / 4];
            res.out_byte = d ^ w[8 * (byte_pos % 4) +: 8];
            res.last_out = l;
            res.wrapped = wrapped;
            byte_pos++;
            want_q.push_back(res);
        endfunction

        function void check_result(logic [7:0] b, logic l, logic w);
            t_cipher_result want;
            if (want_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h/%b/%b",
                         $time, b, l, w);
                errors++;
                return;
            end
            want = want_q.pop_front();
            if (b !== want.out_byte) begin
                $display("%0t: out_byte: expected %h, actual %h", $time, want.out_byte, b);
                errors++;
            end
            if (l !== want.last_out) begin
                $display("%0t: last_out: expected %b, actual %b", $time, want.last_out, l);
                errors++;
            end
            if (w !== want.wrapped) begin
                $display("%0t: counter_wrapped: expected %b, actual %b",
                         $time, want.wrapped, w);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    int                    snd_idle_pct;
    int                    rcv_idle_pct;
    int                    quiet_cycles;
    chacha_scoreboard      sb = new();

    cc20_in_if  in_ch ();
    cc20_out_if out_ch ();

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS (ROUNDS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic bit chance(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.out_byte, out_ch.last_out, out_ch.counter_wrapped);
            end
            out_ch.ready <= !chance(rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic l);
        while (chance(snd_idle_pct)) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.last_byte <= l;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(d, l);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return '1;
            2: return 64'h0000_0000_FFFF_FFFF;
            3: return 64'hFFFF_FFFF_FFFF_FFFE;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic reconfigure(input bit every_reg);
        for (int r = 0; r <= CFG_START; r++) begin
            if (every_reg || chance(50)) begin
                write_reg(CFG_IDX_W'(r), pick_value());
            end
        end
        if (chance(30)) begin
            write_reg(chance(50) ? CFG_SPARE0 : CFG_SPARE1, pick_value());
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int snd_pct, input int rcv_pct);
        int sent;
        int len;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(80, 1);
            if (len > n_items - sent) begin
                len = n_items - sent;
            end
            for (int i = 0; i < len; i++) begin
                send_byte(8'($urandom_range(255, 0)), i == len - 1);
            end
            sent += len;
        end
        settle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
        quiet_cycles = 0;
        snd_idle_pct = 26;
        rcv_idle_pct = 65;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        settle();

        // All ones everywhere: the first block wraps the counter at once.
        for (int r = 0; r <= CFG_START; r++) begin
            write_reg(CFG_IDX_W'(r), '1);
        end
        i_cfg_we <= 1'b0;
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h3C, 1'b0);
        settle();

        // Writes to unused indexes must leave the stream and the wrap flag alone.
        write_reg(CFG_SPARE0, '0);
        write_reg(CFG_SPARE1, '1);
        i_cfg_we <= 1'b0;
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);
        settle();

        write_reg(CFG_START, '0);
        i_cfg_we <= 1'b0;
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);
        settle();

        reconfigure(1'b1);
        run_phase(PHASE_ITEMS, 26, 65);
        reconfigure(1'b0);
        run_phase(PHASE_ITEMS, 26, 65);
        reconfigure(1'b1);
        run_phase(PHASE_ITEMS, 65, 26);
        reconfigure(1'b0);
        run_phase(PHASE_ITEMS, 65, 26);
        reconfigure(1'b1);
        run_phase(PHASE_ITEMS, 0, 0);
        reconfigure(1'b0);
        run_phase(PHASE_ITEMS, 0, 0);

        repeat (BLOCK_CYCLES + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.want_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
